// ----- rtl/pes_ade_pkg.sv -----
// Package for the PES audio description extractor.
// Holds status codes, stream id and descriptor constants, the result type and
// the extension-offset function. No dependencies.
package pes_ade_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_PRIVATE = 3'd1;
  localparam logic [2:0] ST_BAD_RSVD   = 3'd2;
  localparam logic [2:0] ST_BAD_LEN    = 3'd3;
  localparam logic [2:0] ST_BAD_TAG    = 3'd4;

  // Stream ids that carry no PES header extension.
  localparam logic [7:0] SID_PROGRAM_MAP   = 8'hBC;
  localparam logic [7:0] SID_PRIVATE_2     = 8'hBF;
  localparam logic [7:0] SID_PADDING       = 8'hBE;
  localparam logic [7:0] SID_ECM           = 8'hF0;
  localparam logic [7:0] SID_EMM           = 8'hF1;
  localparam logic [7:0] SID_DIRECTORY     = 8'hFF;
  localparam logic [7:0] SID_DSMCC         = 8'hF2;
  localparam logic [7:0] SID_H222_TYPE_E   = 8'hF8;

  // Header byte positions.
  localparam logic [7:0] POS_STREAM_ID = 8'd3;
  localparam logic [7:0] POS_FLAGS     = 8'd7;
  localparam logic [7:0] POS_SATURATE  = 8'd255;

  // Descriptor layout.
  localparam int unsigned DESC_LEN    = 12;
  localparam logic [7:0]  RSVD_NIBBLE = 8'hF0;
  localparam logic [3:0]  LEN_SHORT   = 4'd8;
  localparam logic [3:0]  LEN_LONG    = 4'd11;
  localparam logic [7:0]  TAG_D       = 8'h44;
  localparam logic [7:0]  TAG_T       = 8'h54;
  localparam logic [7:0]  TAG_G       = 8'h47;
  localparam logic [7:0]  TAG_A       = 8'h41;
  localparam logic [7:0]  VERSION_GAINS = 8'h32;

  typedef logic [7:0] desc_arr_t [DESC_LEN];

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] version;
    logic [7:0] fade;
    logic [7:0] pan;
    logic       gains_present;
    logic [7:0] gain_center;
    logic [7:0] gain_front;
    logic [7:0] gain_surround;
  } result_t;

  // Position of the extension byte: header data length byte at 8, then the
  // optional fields announced by the flags byte.
  function automatic logic [5:0] ext_pos(input logic [7:0] f);
    logic [5:0] p;
    p = 6'd9;
    if (f[7:6] == 2'b10) p = p + 6'd5;
    else if (f[7:6] == 2'b11) p = p + 6'd10;
    if (f[5]) p = p + 6'd6;
    if (f[4]) p = p + 6'd3;
    if (f[3]) p = p + 6'd1;
    if (f[2]) p = p + 6'd1;
    if (f[1]) p = p + 6'd2;
    return p;
  endfunction

endpackage

// ----- rtl/pes_ade_parser.sv -----
// Per-packet parse state and the result logic for one header byte.
// Depends on pes_ade_pkg.
module pes_ade_parser #(
  parameter int unsigned PRIVATE_DATA_BYTES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               data_i,
  input  logic                     last_i,
  output pes_ade_pkg::result_t     result_o
);

  logic [7:0] cnt_q, cnt_d;
  logic       hv_q, hv_d;
  logic [5:0] ext_q, ext_d;
  logic       psf_q, psf_d;
  logic [7:0] desc_q [pes_ade_pkg::DESC_LEN];
  pes_ade_pkg::desc_arr_t desc_n;

  logic       wr_en;
  logic [3:0] wr_idx;
  logic [7:0] ext_pos8;
  logic [7:0] ext_end;
  logic [7:0] idx_full;
  logic [8:0] size;
  logic [8:0] need;

  assign ext_pos8 = {2'b00, ext_q};
  assign ext_end  = ext_pos8 + 8'(pes_ade_pkg::DESC_LEN);
  assign idx_full = cnt_q - ext_pos8 - 8'd1;

  always_comb begin
    hv_d   = hv_q;
    ext_d  = ext_q;
    psf_d  = psf_q;
    wr_en  = 1'b0;
    wr_idx = idx_full[3:0];
    if (cnt_q < 8'd3) begin
      if (data_i != ((cnt_q == 8'd2) ? 8'd1 : 8'd0)) hv_d = 1'b0;
    end else if (cnt_q == pes_ade_pkg::POS_STREAM_ID) begin
      case (data_i) inside
        pes_ade_pkg::SID_PROGRAM_MAP, pes_ade_pkg::SID_PRIVATE_2,
        pes_ade_pkg::SID_PADDING, pes_ade_pkg::SID_ECM, pes_ade_pkg::SID_EMM,
        pes_ade_pkg::SID_DIRECTORY, pes_ade_pkg::SID_DSMCC,
        pes_ade_pkg::SID_H222_TYPE_E: hv_d = 1'b0;
        default: ;
      endcase
    end else if (cnt_q == pes_ade_pkg::POS_FLAGS) begin
      ext_d = pes_ade_pkg::ext_pos(data_i);
      if (!data_i[0]) hv_d = 1'b0;
    end else if (cnt_q > pes_ade_pkg::POS_FLAGS && cnt_q < pes_ade_pkg::POS_SATURATE) begin
      if (cnt_q == ext_pos8) begin
        psf_d = data_i[7];
      end else if (cnt_q > ext_pos8 && cnt_q <= ext_end) begin
        wr_en = 1'b1;
      end
    end
  end

  // The byte being written now is forwarded into the checks.
  always_comb begin
    for (int i = 0; i < pes_ade_pkg::DESC_LEN; i++) begin
      desc_n[i] = (wr_en && wr_idx == 4'(i)) ? data_i : desc_q[i];
    end
  end

  assign size = {1'b0, cnt_q} + 9'd1;
  assign need = {3'b000, ext_d} + 9'd1 + 9'(PRIVATE_DATA_BYTES);

  always_comb begin
    result_o = '0;
    if (!hv_d || size < 9'd8 || !psf_d || need > size) begin
      result_o.status = pes_ade_pkg::ST_NO_PRIVATE;
    end else if ((desc_n[0] & pes_ade_pkg::RSVD_NIBBLE) != pes_ade_pkg::RSVD_NIBBLE) begin
      result_o.status = pes_ade_pkg::ST_BAD_RSVD;
    end else if (desc_n[0][3:0] != pes_ade_pkg::LEN_SHORT &&
                 desc_n[0][3:0] != pes_ade_pkg::LEN_LONG) begin
      result_o.status = pes_ade_pkg::ST_BAD_LEN;
    end else if (desc_n[1] != pes_ade_pkg::TAG_D || desc_n[2] != pes_ade_pkg::TAG_T ||
                 desc_n[3] != pes_ade_pkg::TAG_G || desc_n[4] != pes_ade_pkg::TAG_A ||
                 desc_n[5] != pes_ade_pkg::TAG_D) begin
      result_o.status = pes_ade_pkg::ST_BAD_TAG;
    end else begin
      result_o.status  = pes_ade_pkg::ST_OK;
      result_o.version = desc_n[6];
      result_o.fade    = desc_n[7];
      result_o.pan     = desc_n[8];
      if (desc_n[6] == pes_ade_pkg::VERSION_GAINS) begin
        result_o.gains_present = 1'b1;
        result_o.gain_center   = desc_n[9];
        result_o.gain_front    = desc_n[10];
        result_o.gain_surround = desc_n[11];
      end
    end
  end

  always_comb begin
    cnt_d = (cnt_q == pes_ade_pkg::POS_SATURATE) ? cnt_q : cnt_q + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hv_q  <= 1'b1;
      ext_q <= '0;
      psf_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q <= '0;
        hv_q  <= 1'b1;
        ext_q <= '0;
        psf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        hv_q  <= hv_d;
        ext_q <= ext_d;
        psf_q <= psf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      desc_q[wr_idx] <= data_i;
    end
  end

endmodule

// ----- rtl/pes_audio_description_extractor.sv -----
// Top level of the PES audio description extractor.
// Depends on pes_ade_pkg and pes_ade_parser.
//
// Usage: header bytes of one PES packet enter on the input channel, one byte
// per beat, in_valid_i/in_ready_o, with last_byte_i high on the final byte.
// For each packet exactly one result beat leaves on the output channel,
// out_valid_o/out_ready_i: the status code, the descriptor version, fade and
// pan, and the three gains when the version calls for them.
// Path: the beat carrying last_byte_i waits in the input register, and its
// result is loaded into the result register when that beat leaves it, which
// raises out_valid_o; the result beat is taken when out_ready_i is high.
// Throughput: one byte per cycle, set by the single pass through the parser
// between the input and result registers, while no last byte is held back.
// Stalls: while the result register is full and not taken, bytes that are
// not the last of a packet keep flowing; a last byte waits in the input
// register and in_ready_o drops until the result is taken.
// Reset: asynchronous and active low; it clears the valid flags and the
// parse state so the next byte starts a new packet. The descriptor store is
// not cleared; each packet writes every entry it later reads.
module pes_audio_description_extractor #(
  parameter int unsigned PRIVATE_DATA_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] version_o,
  output logic [7:0] fade_o,
  output logic [7:0] pan_o,
  output logic       gains_present_o,
  output logic [7:0] gain_center_o,
  output logic [7:0] gain_front_o,
  output logic [7:0] gain_surround_o
);

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       s1_adv;

  // Result register.
  logic                 out_valid_q;
  pes_ade_pkg::result_t res_q;
  pes_ade_pkg::result_t res_d;

  // A byte that produces no result never needs the output slot.
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  pes_ade_parser #(
    .PRIVATE_DATA_BYTES(PRIVATE_DATA_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .data_i  (s1_data_q),
    .last_i  (s1_last_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign version_o       = res_q.version;
  assign fade_o          = res_q.fade;
  assign pan_o           = res_q.pan;
  assign gains_present_o = res_q.gains_present;
  assign gain_center_o   = res_q.gain_center;
  assign gain_front_o    = res_q.gain_front;
  assign gain_surround_o = res_q.gain_surround;

endmodule

// ----- rtl/pes_ade_checker.sv -----
// Port-level checks for the PES audio description extractor, bound to the
// top level. Depends on pes_ade_pkg.
module pes_ade_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [7:0] version_o,
  input logic [7:0] fade_o,
  input logic [7:0] pan_o,
  input logic       gains_present_o,
  input logic [7:0] gain_center_o,
  input logic [7:0] gain_front_o,
  input logic [7:0] gain_surround_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(version_o) && $stable(gain_surround_o))
    else $error("result beat changed while stalled");

  // Descriptor values are zero unless the descriptor passed every check.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pes_ade_pkg::ST_OK |->
    version_o == 8'd0 && fade_o == 8'd0 && pan_o == 8'd0 && !gains_present_o)
    else $error("descriptor fields set on a failed packet");

  // Gains only with an accepted descriptor of the gain-carrying version.
  a_gains_ver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gains_present_o |->
    status_o == pes_ade_pkg::ST_OK && version_o == pes_ade_pkg::VERSION_GAINS)
    else $error("gains flagged without matching version");

  a_gains_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gains_present_o |->
    gain_center_o == 8'd0 && gain_front_o == 8'd0 && gain_surround_o == 8'd0)
    else $error("gain bytes set without gains flag");

endmodule

bind pes_audio_description_extractor pes_ade_checker u_pes_ade_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for pes_audio_description_extractor.
// Sends PES headers a beat at a time and checks every result against its own
// parser of the header. Depends on pes_ade_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PRIVATE_DATA_BYTES = 16;
  localparam int unsigned NUM_DIRECTED       = 25;
  localparam int unsigned RANDOM_BYTES       = 750;
  localparam int unsigned RX_HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES       = 8;
  localparam int unsigned REPORT_LIMIT       = 10;

  // One header to send. A noise header is random bytes throughout; otherwise
  // the start code, stream id, flags, extension byte and the descriptor are
  // placed where a real header has them and the rest is random. A length of
  // zero means the header ends right after its private data.
  typedef struct packed {
    logic [7:0] sid;
    logic [7:0] flags;
    logic [7:0] ext_byte;
    logic [7:0] desc0;
    logic [7:0] version;
    logic       bad_start;
    logic       bad_tag;
    logic       noise;
    logic [8:0] length;
    logic       typed;
    logic [2:0] want;
  } packet_spec_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [7:0] version_o;
  logic [7:0] fade_o;
  logic [7:0] pan_o;
  logic       gains_present_o;
  logic [7:0] gain_center_o;
  logic [7:0] gain_front_o;
  logic [7:0] gain_surround_o;

  pes_audio_description_extractor #(
    .PRIVATE_DATA_BYTES(PRIVATE_DATA_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .version_o      (version_o),
    .fade_o         (fade_o),
    .pan_o          (pan_o),
    .gains_present_o(gains_present_o),
    .gain_center_o  (gain_center_o),
    .gain_front_o   (gain_front_o),
    .gain_surround_o(gain_surround_o)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results the parser below has predicted and the block has not yet shown.
  pes_ade_pkg::result_t expected_results [$];
  int unsigned  errors = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  packets_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  status_seen [5] = '{0, 0, 0, 0, 0};

  // Idle rates in percent for the two sides, changed per phase.
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;

  // A long receiver hold-off is asked for by bumping holds_asked.
  int unsigned  holds_asked = 0;
  int unsigned  holds_done = 0;
  int unsigned  rx_hold_left = 0;

  logic [7:0]   rejected_ids [8];
  packet_spec_t directed_rows [NUM_DIRECTED];

  // Parser state, kept apart from the block's.
  int unsigned  hp_count = 0;
  bit           hp_header_ok = 1'b1;
  int unsigned  hp_ext_pos = 0;
  bit           hp_private = 1'b0;
  logic [7:0]   hp_desc [pes_ade_pkg::DESC_LEN];

  // Position of the PES extension byte: the header data length byte sits at
  // position 8, then come the optional fields that the flags byte announces.
  // The two PTS/DTS bits give nothing, a PTS alone, or PTS plus DTS.
  function automatic int unsigned ext_offset(input logic [7:0] f);
    return 9 + (f[7] ? (f[6] ? 10 : 5) : 0) + (f[5] ? 6 : 0) + (f[4] ? 3 : 0)
           + (f[3] ? 1 : 0) + (f[2] ? 1 : 0) + (f[1] ? 2 : 0);
  endfunction

  // Takes one accepted header beat. Returns 1 and the predicted result when
  // the beat closes the packet; the packet state then starts over.
  function automatic bit parse_header_byte(input logic [7:0] b, input bit last,
                                           output pes_ade_pkg::result_t res);
    int unsigned pos;
    int unsigned size;
    pos = hp_count;
    res = '0;
    if (pos < pes_ade_pkg::POS_STREAM_ID) begin
      // Start code prefix 00 00 01.
      if (b != ((pos == 2) ? 8'h01 : 8'h00)) hp_header_ok = 1'b0;
    end else if (pos == pes_ade_pkg::POS_STREAM_ID) begin
      case (b)
        pes_ade_pkg::SID_PROGRAM_MAP, pes_ade_pkg::SID_PRIVATE_2,
        pes_ade_pkg::SID_PADDING, pes_ade_pkg::SID_ECM, pes_ade_pkg::SID_EMM,
        pes_ade_pkg::SID_DIRECTORY, pes_ade_pkg::SID_DSMCC,
        pes_ade_pkg::SID_H222_TYPE_E: hp_header_ok = 1'b0;
        default: ;
      endcase
    end else if (pos == pes_ade_pkg::POS_FLAGS) begin
      hp_ext_pos = ext_offset(b);
      if (!b[0]) hp_header_ok = 1'b0;
    end else if (pos > pes_ade_pkg::POS_FLAGS && pos < pes_ade_pkg::POS_SATURATE) begin
      // The private data flag is taken from the extension byte itself.
      if (pos == hp_ext_pos) begin
        hp_private = b[7];
      end else if (pos > hp_ext_pos && pos <= hp_ext_pos + pes_ade_pkg::DESC_LEN) begin
        hp_desc[pos - hp_ext_pos - 1] = b;
      end
    end
    if (hp_count < pes_ade_pkg::POS_SATURATE) hp_count++;
    if (!last) return 1'b0;

    size = pos + 1;
    if (!hp_header_ok || size < 8 || !hp_private ||
        hp_ext_pos + 1 + PRIVATE_DATA_BYTES > size) begin
      res.status = pes_ade_pkg::ST_NO_PRIVATE;
    end else if ((hp_desc[0] & pes_ade_pkg::RSVD_NIBBLE) != pes_ade_pkg::RSVD_NIBBLE) begin
      res.status = pes_ade_pkg::ST_BAD_RSVD;
    end else if (hp_desc[0][3:0] != pes_ade_pkg::LEN_SHORT &&
                 hp_desc[0][3:0] != pes_ade_pkg::LEN_LONG) begin
      res.status = pes_ade_pkg::ST_BAD_LEN;
    end else if (hp_desc[1] != pes_ade_pkg::TAG_D || hp_desc[2] != pes_ade_pkg::TAG_T ||
                 hp_desc[3] != pes_ade_pkg::TAG_G || hp_desc[4] != pes_ade_pkg::TAG_A ||
                 hp_desc[5] != pes_ade_pkg::TAG_D) begin
      res.status = pes_ade_pkg::ST_BAD_TAG;
    end else begin
      res.status  = pes_ade_pkg::ST_OK;
      res.version = hp_desc[6];
      res.fade    = hp_desc[7];
      res.pan     = hp_desc[8];
      if (hp_desc[6] == pes_ade_pkg::VERSION_GAINS) begin
        res.gains_present = 1'b1;
        res.gain_center   = hp_desc[9];
        res.gain_front    = hp_desc[10];
        res.gain_surround = hp_desc[11];
      end
    end
    hp_count     = 0;
    hp_header_ok = 1'b1;
    hp_ext_pos   = 0;
    hp_private   = 1'b0;
    return 1'b1;
  endfunction

  // Builds one header from its description and sends it beat by beat. Each
  // accepted beat goes through the parser; a typed row replaces the
  // predicted result with the one written in the table.
  task automatic send_packet(input packet_spec_t spec);
    logic [7:0]  pkt [$];
    int unsigned ext;
    int unsigned natural_len;
    int unsigned total;
    int unsigned k;
    pes_ade_pkg::result_t res;
    ext         = ext_offset(spec.flags);
    natural_len = ext + 1 + PRIVATE_DATA_BYTES;
    total       = (spec.length == 0) ? natural_len : spec.length;
    pkt         = {};
    for (k = 0; k < ((total > natural_len) ? total : natural_len); k++)
      pkt.push_back(8'($urandom_range(0, 255)));
    if (!spec.noise) begin
      pkt[0]       = 8'h00;
      pkt[1]       = 8'h00;
      pkt[2]       = 8'h01;
      pkt[3]       = spec.sid;
      pkt[7]       = spec.flags;
      pkt[ext]     = spec.ext_byte;
      pkt[ext + 1] = spec.desc0;
      pkt[ext + 2] = pes_ade_pkg::TAG_D;
      pkt[ext + 3] = pes_ade_pkg::TAG_T;
      pkt[ext + 4] = pes_ade_pkg::TAG_G;
      pkt[ext + 5] = pes_ade_pkg::TAG_A;
      pkt[ext + 6] = pes_ade_pkg::TAG_D;
      pkt[ext + 7] = spec.version;
      if (spec.bad_start) begin
        k = $urandom_range(0, 2);
        pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
      end
      if (spec.bad_tag) begin
        k = ext + 2 + $urandom_range(0, 4);
        pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
      end
    end

    for (k = 0; k < total; k++) begin
      // Random gap before the beat; valid drops only while no beat is offered.
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= pkt[k];
      last_byte_i <= (k == total - 1);
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      // Beats past the saturation point are ignored by the block.
      if (k < pes_ade_pkg::POS_SATURATE) bytes_sent++;
      if (parse_header_byte(pkt[k], k == total - 1, res)) begin
        if (spec.typed) begin
          res        = '0;
          res.status = spec.want;
        end
        expected_results.push_back(res);
      end
    end
    packets_sent++;
  endtask

  // Receiver: random ready, or held low for a long stretch on request so that
  // the result register stays full and the block has to stall its input.
  always @(posedge clk_i) begin
    if (holds_done != holds_asked) begin
      holds_done   = holds_asked;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every accepted result beat is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    pes_ade_pkg::result_t seen;
    pes_ade_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {status_o, version_o, fade_o, pan_o, gains_present_o,
              gain_center_o, gain_front_o, gain_surround_o};
      if (seen.status <= pes_ade_pkg::ST_BAD_TAG) status_seen[seen.status]++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: st=%0d ver=%02h",
                   $realtime, seen.status, seen.version);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (seen.status !== want.status || seen.version !== want.version ||
            seen.fade !== want.fade || seen.pan !== want.pan ||
            seen.gains_present !== want.gains_present ||
            seen.gain_center !== want.gain_center ||
            seen.gain_front !== want.gain_front ||
            seen.gain_surround !== want.gain_surround) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: mismatch: got  st=%0d ver=%02h fade=%02h pan=%02h g=%b %02h %02h %02h",
                     $realtime, seen.status, seen.version, seen.fade, seen.pan,
                     seen.gains_present, seen.gain_center, seen.gain_front,
                     seen.gain_surround);
            $display("%0t: mismatch: want st=%0d ver=%02h fade=%02h pan=%02h g=%b %02h %02h %02h",
                     $realtime, want.status, want.version, want.fade, want.pan,
                     want.gains_present, want.gain_center, want.gain_front,
                     want.gain_surround);
          end
        end
      end
    end
  end

  initial begin
    packet_spec_t spec;
    int unsigned  phase;
    int unsigned  phase_start;
    int unsigned  natural_len;
    int unsigned  i;

    rejected_ids = '{pes_ade_pkg::SID_PROGRAM_MAP, pes_ade_pkg::SID_PRIVATE_2,
                     pes_ade_pkg::SID_PADDING, pes_ade_pkg::SID_ECM, pes_ade_pkg::SID_EMM,
                     pes_ade_pkg::SID_DIRECTORY, pes_ade_pkg::SID_DSMCC,
                     pes_ade_pkg::SID_H222_TYPE_E};

    // Columns: sid, flags, extension byte, descriptor byte 0, version,
    // bad start code, bad tag, noise, length, typed, typed status.
    directed_rows = '{
      // Well-formed headers with different optional-field layouts.
      '{8'hC0, 8'h01, 8'h80, 8'hF8, pes_ade_pkg::VERSION_GAINS, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0,
        pes_ade_pkg::ST_OK},
      '{8'hBD, 8'hFF, 8'hFF, 8'hFB, 8'h31, 1'b0, 1'b0, 1'b0, 9'd0,   1'b0, pes_ade_pkg::ST_OK},
      '{8'hE0, 8'h81, 8'h80, 8'hF8, pes_ade_pkg::VERSION_GAINS, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0,
        pes_ade_pkg::ST_OK},
      '{8'hC1, 8'h41, 8'hC5, 8'hF8, 8'h00, 1'b0, 1'b0, 1'b0, 9'd0,   1'b0, pes_ade_pkg::ST_OK},
      '{8'hC2, 8'hC3, 8'h80, 8'hFB, 8'hFF, 1'b0, 1'b0, 1'b0, 9'd60,  1'b0, pes_ade_pkg::ST_OK},
      // Every rejected stream id.
      '{pes_ade_pkg::SID_PROGRAM_MAP, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_PRIVATE_2, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_PADDING, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_ECM, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_EMM, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_DIRECTORY, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_DSMCC, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{pes_ade_pkg::SID_H222_TYPE_E, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0, 1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      // Broken start code, extension flag clear, private data flag clear.
      '{8'hC0, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b1, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{8'hC0, 8'h00, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{8'hC0, 8'h01, 8'h7F, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      // Short packets: one beat, seven beats, private data one beat short.
      '{8'hC0, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd1,   1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{8'hC0, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd7,   1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      '{8'hC0, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd25,  1'b1,
        pes_ade_pkg::ST_NO_PRIVATE},
      // Descriptor faults: reserved nibble, lengths 9, 15 and 0, then the tag.
      '{8'hC0, 8'h01, 8'h80, 8'h78, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_BAD_RSVD},
      '{8'hC0, 8'h01, 8'h80, 8'hF9, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_BAD_LEN},
      '{8'hC0, 8'h01, 8'h80, 8'hFF, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_BAD_LEN},
      '{8'hC0, 8'h01, 8'h80, 8'hF0, 8'h32, 1'b0, 1'b0, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_BAD_LEN},
      '{8'hC0, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b1, 1'b0, 9'd0,   1'b1,
        pes_ade_pkg::ST_BAD_TAG},
      // Long packet past the saturation point.
      '{8'hC0, 8'h01, 8'h80, 8'hF8, 8'h32, 1'b0, 1'b0, 1'b0, 9'd300, 1'b0, pes_ade_pkg::ST_OK}
    };

    tx_idle_pct = 17;
    rx_idle_pct = 65;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) send_packet(directed_rows[i]);

    // Three random phases: sender mostly busy and receiver mostly stalled,
    // then the other way round, then both at full rate. Each phase ends with
    // the sender paused until every predicted result has come out.
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 65 : 0;
      rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 17 : 0;
      phase_start = bytes_sent;

      if (phase == 1) begin
        // Receiver holds off while short packets keep coming, so a result
        // sits in the output register and the input has to stall.
        holds_asked++;
        for (i = 0; i < 8; i++) begin
          spec        = '0;
          spec.noise  = 1'b1;
          spec.length = 9'($urandom_range(1, 12));
          send_packet(spec);
        end
      end

      while (bytes_sent - phase_start < RANDOM_BYTES / 3) begin
        // Start from a well-formed header with random content.
        spec          = '0;
        spec.sid      = 8'hC0 | 8'($urandom_range(0, 31));
        spec.flags    = 8'($urandom_range(0, 255)) | 8'h01;
        spec.ext_byte = 8'($urandom_range(0, 255)) | 8'h80;
        spec.desc0    = $urandom_range(0, 1) ? 8'hF8 : 8'hFB;
        spec.version  = $urandom_range(0, 1) ? pes_ade_pkg::VERSION_GAINS
                                             : 8'($urandom_range(0, 255));
        natural_len   = ext_offset(spec.flags) + 1 + PRIVATE_DATA_BYTES;
        if ($urandom_range(0, 29) == 0)
          spec.length = 9'($urandom_range(256, 300));
        else
          spec.length = 9'(natural_len + $urandom_range(0, 4));
        i = $urandom_range(0, 99);
        if (i >= 85) begin
          spec.noise  = 1'b1;
          spec.length = 9'($urandom_range(1, 40));
        end else if (i >= 65) begin
          // Break exactly one thing about it.
          case ($urandom_range(0, 6))
            0: spec.bad_start = 1'b1;
            1: spec.sid = rejected_ids[$urandom_range(0, 7)];
            2: spec.flags = spec.flags & 8'hFE;
            3: spec.ext_byte = spec.ext_byte & 8'h7F;
            4: spec.desc0 = 8'($urandom_range(0, 255));
            5: spec.bad_tag = 1'b1;
            default: spec.length = 9'($urandom_range(1, natural_len - 1));
          endcase
        end
        send_packet(spec);
      end

      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (expected_results.size() != 0);
    end

    // Drain for DRAIN_CYCLES to catch any stray result beats.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    errors += expected_results.size();

    $display("Sent %0d headers (%0d counted beats), %0d results checked, %0d errors.",
             packets_sent, bytes_sent, results_checked, errors);
    $display("Status mix: ok %0d, no private data %0d, reserved %0d, length %0d, tag %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0) begin
      $display("** pes_audio_description_extractor: PASSED **");
    end else begin
      $display("** pes_audio_description_extractor: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("** pes_audio_description_extractor: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pes_ade_pkg.sv
rtl/pes_ade_parser.sv
rtl/pes_audio_description_extractor.sv
rtl/pes_ade_checker.sv
tb/sv/tb.sv
